FILE: hw/rtl/sdes_cbc_pkg.sv
// Shared constants, types and S-DES permutation/round functions for the CBC byte cipher.
`timescale 1ns / 1ps

package sdes_cbc_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [9:0] key_t;
  typedef logic [3:0] nib_t;

  localparam key_t  KEY_RST = 10'd509;
  localparam byte_t IV_RST  = 8'd170;

  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_KEY  = 2'd0;
  localparam logic [1:0] REG_IV   = 2'd1;
  localparam logic [1:0] REG_MODE = 2'd2;

  localparam logic [1:0] SBOX0 [0:3][0:3] = '{
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd2, 2'd1, 2'd3},
    '{2'd3, 2'd1, 2'd3, 2'd2}
  };

  localparam logic [1:0] SBOX1 [0:3][0:3] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd1, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd3}
  };

  function automatic key_t p10(input key_t k);
    return {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
  endfunction

  function automatic byte_t p8(input key_t t);
    return {t[4], t[7], t[3], t[6], t[2], t[5], t[0], t[1]};
  endfunction

  function automatic byte_t perm_ip(input byte_t v);
    return {v[6], v[2], v[5], v[7], v[4], v[0], v[3], v[1]};
  endfunction

  function automatic byte_t perm_ipi(input byte_t v);
    return {v[4], v[7], v[5], v[3], v[1], v[6], v[0], v[2]};
  endfunction

  function automatic byte_t subkey1(input key_t k);
    key_t t;
    t = p10(k);
    return p8({t[8:5], t[9], t[3:0], t[4]});
  endfunction

  function automatic byte_t subkey2(input key_t k);
    key_t t;
    t = p10(k);
    // three-place left rotation of each half in total
    return p8({t[6:5], t[9:7], t[1:0], t[4:2]});
  endfunction

  function automatic byte_t round_fk(input byte_t b, input byte_t sk);
    nib_t  rh;
    byte_t x;
    nib_t  s;
    rh = b[3:0];
    x  = {rh[0], rh[3], rh[2], rh[1], rh[2], rh[1], rh[0], rh[3]} ^ sk;
    s  = {SBOX0[{x[7], x[4]}][{x[6], x[5]}], SBOX1[{x[3], x[0]}][{x[2], x[1]}]};
    return {b[7:4] ^ {s[2], s[0], s[1], s[3]}, rh};
  endfunction

  function automatic byte_t block_cipher(input byte_t v, input byte_t ka, input byte_t kb);
    byte_t t;
    t = round_fk(perm_ip(v), ka);
    t = round_fk({t[3:0], t[7:4]}, kb);
    return perm_ipi(t);
  endfunction

endpackage

FILE: hw/rtl/sdes_cbc_byte_cipher.sv
// S-DES byte cipher in CBC mode with APB-style configuration registers.
// Data path: an accepted byte is held in the input register, then its result in the result
// register; a busy result register keeps the byte waiting in the input register.
// Throughput: one byte per cycle while out_ready holds; the whole cipher and chain
// update sit between the input register and the result/chain registers.
// Reset (synchronous, rst_n low): pipeline empty, key 509, IV 170, encrypt mode,
// chain value 170.
`timescale 1ns / 1ps

module sdes_cbc_byte_cipher (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sdes_cbc_pkg::byte_t                in_data_in,
  input  logic                               in_chain_restart,
  output logic                               out_valid,
  input  logic                               out_ready,
  output sdes_cbc_pkg::byte_t                out_data_out,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [sdes_cbc_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [sdes_cbc_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [sdes_cbc_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                               cfg_pready
);
  import sdes_cbc_pkg::*;

  key_t       key_r;
  byte_t      iv_r;
  logic       mode_r;
  byte_t      chain_r, chain_nxt;
  logic       s1_valid_r;
  byte_t      s1_data_r;
  logic       s1_restart_r;
  logic       out_valid_r;
  byte_t      out_data_r, out_data_nxt;
  logic       s1_adv;
  logic       cfg_wr;
  logic [1:0] cfg_idx;
  byte_t      k1, k2, chain_use, bc_in, bc_out;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_prdata = '0;
    case (cfg_idx)
      REG_KEY:  cfg_prdata = {{(CFG_DW-10){1'b0}}, key_r};
      REG_IV:   cfg_prdata = {{(CFG_DW-8){1'b0}}, iv_r};
      REG_MODE: cfg_prdata = {{(CFG_DW-1){1'b0}}, mode_r};
      default:  cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= KEY_RST;
      iv_r   <= IV_RST;
      mode_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KEY:  key_r  <= cfg_pwdata[9:0];
        REG_IV:   iv_r   <= cfg_pwdata[7:0];
        REG_MODE: mode_r <= cfg_pwdata[0];
        default:  ;
      endcase
    end
  end

  // advance the input stage whenever the result register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  assign k1        = subkey1(key_r);
  assign k2        = subkey2(key_r);
  assign chain_use = s1_restart_r ? iv_r : chain_r;
  assign bc_in     = mode_r ? s1_data_r : (s1_data_r ^ chain_use);
  assign bc_out    = mode_r ? block_cipher(bc_in, k2, k1) : block_cipher(bc_in, k1, k2);

  always_comb begin
    if (mode_r) begin
      out_data_nxt = bc_out ^ chain_use;
      chain_nxt    = s1_data_r;
    end else begin
      out_data_nxt = bc_out;
      chain_nxt    = bc_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      chain_r     <= IV_RST;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        chain_r     <= chain_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r    <= in_data_in;
      s1_restart_r <= in_chain_restart;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;

  // encrypt chains on the ciphertext just produced
  a_enc_chain: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !mode_r |=> chain_r == out_data_r)
    else $error("encrypt chain value does not match result");

  // decrypt chains on the ciphertext that came in
  a_dec_chain: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && mode_r |=> chain_r == $past(s1_data_r))
    else $error("decrypt chain value does not match input byte");

  // an empty result register never stalls the input side
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

FILE: bench/tb.sv
// Self-checking bench for the S-DES CBC byte cipher: directed, stall and random traffic.
`timescale 1ns / 1ps

module tb;
  import sdes_cbc_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;  // first index past the register list

  // bit selections, MSB-first, bit 1 = most significant input bit
  localparam logic [39:0] P10_TAB = {4'd3, 4'd5, 4'd2, 4'd7, 4'd4, 4'd10, 4'd1, 4'd9, 4'd8, 4'd6};
  localparam logic [39:0] P8_TAB  = {8'd0, 4'd6, 4'd3, 4'd7, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9};
  localparam logic [39:0] IP_TAB  = {8'd0, 4'd2, 4'd6, 4'd3, 4'd1, 4'd4, 4'd8, 4'd5, 4'd7};
  localparam logic [39:0] IPI_TAB = {8'd0, 4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd2, 4'd8, 4'd6};
  localparam logic [39:0] EP_TAB  = {8'd0, 4'd4, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd1};
  localparam logic [39:0] P4_TAB  = {24'd0, 4'd2, 4'd4, 4'd3, 4'd1};

  // S-boxes indexed by {row, column}
  localparam logic [1:0] S0_TAB [16] = '{
    2'd1, 2'd0, 2'd3, 2'd2,  2'd3, 2'd2, 2'd1, 2'd0,
    2'd0, 2'd2, 2'd1, 2'd3,  2'd3, 2'd1, 2'd3, 2'd2
  };
  localparam logic [1:0] S1_TAB [16] = '{
    2'd0, 2'd1, 2'd2, 2'd3,  2'd2, 2'd0, 2'd1, 2'd3,
    2'd3, 2'd0, 2'd1, 2'd0,  2'd2, 2'd1, 2'd0, 2'd3
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  byte_t             in_data_in = '0;
  logic              in_chain_restart = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  byte_t             out_data_out;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // mirror of the block's registers and chain
  key_t  key_m     = KEY_RST;
  byte_t iv_m      = IV_RST;
  logic  decrypt_m = 1'b0;
  byte_t chain_m   = IV_RST;

  byte_t expected_bytes[$];
  int    mismatch_count = 0;
  int    snd_idle_pct = 0;
  int    rcv_idle_pct = 0;
  int    hold_left = 0;

  sdes_cbc_byte_cipher u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_in       (in_data_in),
    .in_chain_restart (in_chain_restart),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_out     (out_data_out),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic logic [9:0] permute(logic [9:0] v, logic [39:0] tab, int nin, int nout);
    logic [9:0] r;
    int         pos;
    r = '0;
    for (int i = 0; i < nout; i++) begin
      pos = int'(tab[4*(nout-1-i) +: 4]);
      r = {r[8:0], v[nin-pos]};
    end
    return r;
  endfunction

  function automatic logic [4:0] rot5(logic [4:0] h, int k);
    return (h << k) | (h >> (5 - k));
  endfunction

  // {K1, K2}
  function automatic logic [15:0] derive_subkeys(key_t k);
    logic [9:0] t;
    logic [9:0] p1;
    logic [9:0] p2;
    logic [4:0] lh;
    logic [4:0] rh;
    t  = permute(k, P10_TAB, 10, 10);
    lh = rot5(t[9:5], 1);
    rh = rot5(t[4:0], 1);
    p1 = permute({lh, rh}, P8_TAB, 10, 8);
    lh = rot5(lh, 2);
    rh = rot5(rh, 2);
    p2 = permute({lh, rh}, P8_TAB, 10, 8);
    return {p1[7:0], p2[7:0]};
  endfunction

  function automatic byte_t feistel(byte_t b, byte_t sk);
    logic [9:0] x;
    logic [9:0] p;
    logic [3:0] s;
    x = permute({6'd0, b[3:0]}, EP_TAB, 4, 8) ^ {2'd0, sk};
    s = {S0_TAB[{x[7], x[4], x[6], x[5]}], S1_TAB[{x[3], x[0], x[2], x[1]}]};
    p = permute({6'd0, s}, P4_TAB, 4, 4);
    return {b[7:4] ^ p[3:0], b[3:0]};
  endfunction

  function automatic byte_t encipher(byte_t v, byte_t ka, byte_t kb);
    logic [9:0] t;
    byte_t      b;
    t = permute({2'd0, v}, IP_TAB, 8, 8);
    b = feistel(t[7:0], ka);
    b = feistel({b[3:0], b[7:4]}, kb);
    t = permute({2'd0, b}, IPI_TAB, 8, 8);
    return t[7:0];
  endfunction

  // advance the mirrored chain by one byte and return the expected output
  function automatic byte_t predict_cbc_byte(byte_t d, logic restart);
    logic [15:0] keys;
    byte_t       res;
    if (restart) chain_m = iv_m;
    keys = derive_subkeys(key_m);
    if (decrypt_m) begin
      res = encipher(d, keys[7:0], keys[15:8]) ^ chain_m;
      chain_m = d;
    end else begin
      res = encipher(d ^ chain_m, keys[15:8], keys[7:0]);
      chain_m = res;
    end
    return res;
  endfunction

  // receiver: long hold-off first, random stalls otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $error("data_out: no transaction expected, actual %02h", out_data_out);
        mismatch_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_data_out !== want) begin
          $error("data_out mismatch: expected %02h, actual %02h", want, out_data_out);
          mismatch_count++;
        end
      end
    end
  end

  // offer one byte; valid stays high on return
  task automatic push_byte(byte_t d, logic restart);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data_in = d;
    in_chain_restart = restart;
    do @(posedge clk); while (!in_ready);
    expected_bytes.push_back(predict_cbc_byte(d, restart));
  endtask

  // drop valid and hold until every result is back
  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_KEY:  key_m = val[9:0];
      REG_IV:   iv_m = val[7:0];
      REG_MODE: decrypt_m = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic cfg_check(logic [1:0] idx, logic [31:0] want, int width);
    logic [31:0] mask;
    logic [31:0] got;
    mask = (32'd1 << width) - 32'd1;
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = {idx, 2'b00};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    if ((got & mask) !== (want & mask)) begin
      $error("register %0d mismatch: expected %0h, actual %0h", idx, want & mask, got & mask);
      mismatch_count++;
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic check_registers;
    cfg_check(REG_KEY, {22'd0, key_m}, 10);
    cfg_check(REG_IV, {24'd0, iv_m}, 8);
    cfg_check(REG_MODE, {31'd0, decrypt_m}, 1);
  endtask

  // reset key, IV and chain, with no restart on the first bytes
  task automatic test_reset_state;
    check_registers();
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h5A, 1'b0);
    drain();
  endtask

  task automatic test_key_extremes;
    cfg_write(REG_KEY, 32'd0);
    cfg_write(REG_IV, 32'd0);
    check_registers();
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    drain();
    cfg_write(REG_KEY, 32'd1023);
    cfg_write(REG_IV, 32'd255);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    drain();
    cfg_write(REG_MODE, 32'd1);
    check_registers();
    push_byte(8'h81, 1'b1);
    push_byte(8'h7E, 1'b0);
    push_byte(8'h00, 1'b0);
    drain();
  endtask

  // upper bits ignored, spare index ignored, IV write leaves the chain alone
  task automatic test_iv_write_and_spare;
    cfg_write(REG_KEY, 32'hA5A5_A9E7);
    cfg_write(REG_IV, 32'hFFFF_FF3C);
    cfg_write(REG_MODE, 32'hFFFF_FFFE);
    cfg_write(REG_SPARE, 32'hFFFF_FFFF);
    check_registers();
    push_byte(8'h12, 1'b1);
    push_byte(8'hC3, 1'b0);
    drain();
    cfg_write(REG_IV, 32'h0000_0099);
    push_byte(8'h44, 1'b0);
    push_byte(8'h44, 1'b1);
    drain();
    cfg_write(REG_MODE, 32'h8000_0001);
    push_byte(8'hE1, 1'b0);
    push_byte(8'h1E, 1'b1);
    drain();
  endtask

  // receiver stalls long enough for the block to fill and stall its input
  task automatic test_backpressure;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    @(posedge clk);
    hold_left = 64;
    for (int i = 0; i < 24; i++) push_byte(byte_t'($urandom), (i == 0));
    drain();
  endtask

  task automatic randomize_config;
    logic [31:0] val;
    val = $urandom;
    case ($urandom_range(3))
      0: val[9:0] = 10'd0;
      1: val[9:0] = 10'd1023;
      default: ;
    endcase
    cfg_write(REG_KEY, val);
    val = $urandom;
    case ($urandom_range(3))
      0: val[7:0] = 8'd0;
      1: val[7:0] = 8'd255;
      default: ;
    endcase
    cfg_write(REG_IV, val);
    cfg_write(REG_MODE, $urandom);
  endtask

  // random messages; most start with a restart, some continue the old chain
  task automatic test_random(int n_items, int snd_pct, int rcv_pct);
    int sent;
    int len;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(7) == 0) begin
        drain();
        randomize_config();
      end
      len = $urandom_range(1, 24);
      for (int i = 0; i < len; i++) begin
        push_byte(byte_t'($urandom), (i == 0) && ($urandom_range(9) != 0));
        sent++;
        // pause mid-message until everything is back
        if ($urandom_range(63) == 0) drain();
      end
    end
    drain();
  endtask

  initial begin
    snd_idle_pct = 19;
    rcv_idle_pct = 67;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_state();
    test_key_extremes();
    test_iv_write_and_spare();
    test_backpressure();
    test_random(420, 19, 67);
    test_random(420, 67, 19);
    test_random(420, 0, 0);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sdes_cbc_byte_cipher verification clean");
    end else begin
      $display("sdes_cbc_byte_cipher verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("sdes_cbc_byte_cipher verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/sdes_cbc_pkg.sv
hw/rtl/sdes_cbc_byte_cipher.sv
bench/tb.sv
